// ===== rtl/core/stmvp_pkg.sv =====
package stmvp_pkg;

  localparam int DIM   = 6;
  localparam int HALF  = DIM / 2;
  localparam int PAIRS = DIM / 2;
  localparam int FRAC  = 16;

  localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
  localparam logic signed [31:0] ZERO_Q16 = 32'sh0000_0000;
  localparam logic signed [31:0] Q16_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN  = 32'sh8000_0000;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_VECTOR = 1'b1
  } op_t;

  typedef logic        [2:0]  idx_t;
  typedef logic signed [31:0] q16_t;
  // Coefficient carries one more bit: negating the most negative entry gives +2^31.
  typedef logic signed [32:0] coef_t;
  typedef logic signed [64:0] prod_t;
  typedef logic signed [65:0] psum_t;
  typedef logic signed [67:0] acc_t;

  typedef q16_t  [DIM-1:0] q16_vec_t;
  typedef coef_t [DIM-1:0] coef_row_t;
  typedef coef_row_t [DIM-1:0] coef_mat_t;
  typedef acc_t  [DIM-1:0] acc_vec_t;

  // Per-stage load enables of the lane pipeline.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/stmvp_mstore.sv =====
module stmvp_mstore (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  stmvp_pkg::idx_t    wr_row,
  input  stmvp_pkg::idx_t    wr_col,
  input  stmvp_pkg::q16_t    wr_data,
  input  logic               use_inverse,
  output stmvp_pkg::coef_mat_t coef
);
  import stmvp_pkg::*;

  q16_t mat_r [DIM][DIM];

  // Out-of-range row/col matches no entry, so the write is dropped.
  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (!rst_n) begin
          mat_r[r][c] <= (r == c) ? ONE_Q16 : ZERO_Q16;
        end else if (wr_en && wr_row == idx_t'(r) && wr_col == idx_t'(c)) begin
          mat_r[r][c] <= wr_data;
        end
      end
    end
  end

  // Symplectic inverse of [A B; C D] is [D^T -B^T; -C^T A^T].
  always_comb begin
    int    sr;
    int    sc;
    logic  ng;
    coef_t ext;
    coef_t inv;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (r < HALF && c < HALF) begin
          sr = c + HALF; sc = r + HALF; ng = 1'b0;
        end else if (r < HALF) begin
          sr = c - HALF; sc = r + HALF; ng = 1'b1;
        end else if (c < HALF) begin
          sr = c + HALF; sc = r - HALF; ng = 1'b1;
        end else begin
          sr = c - HALF; sc = r - HALF; ng = 1'b0;
        end
        ext = coef_t'(mat_r[sr][sc]);
        inv = ng ? -ext : ext;
        coef[r][c] = use_inverse ? inv : coef_t'(mat_r[r][c]);
      end
    end
  end

endmodule

// ===== rtl/core/stmvp_lane.sv =====
module stmvp_lane (
  input  logic                 clk,
  input  stmvp_pkg::pipe_ctl_t ctl,
  input  stmvp_pkg::coef_row_t coef,
  input  stmvp_pkg::q16_vec_t  vec,
  output stmvp_pkg::acc_t      sum
);
  import stmvp_pkg::*;

  coef_row_t coef_r;
  q16_vec_t  vec_r;
  prod_t     prod_r  [DIM];
  prod_t     prod_nxt[DIM];
  psum_t     psum_r  [PAIRS];
  psum_t     psum_nxt[PAIRS];
  acc_t      sum_r;
  acc_t      sum_nxt;

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      prod_nxt[c] = prod_t'($signed(coef_r[c])) * prod_t'($signed(vec_r[c]));
    end
    for (int k = 0; k < PAIRS; k++) begin
      psum_nxt[k] = psum_t'(prod_r[2*k]) + psum_t'(prod_r[2*k+1]);
    end
    sum_nxt = '0;
    for (int k = 0; k < PAIRS; k++) begin
      sum_nxt = sum_nxt + acc_t'(psum_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      coef_r <= coef;
      vec_r  <= vec;
    end
    if (ctl.s2_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.s3_en) begin
      psum_r <= psum_nxt;
    end
    if (ctl.s4_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== rtl/core/stmvp_merge.sv =====
module stmvp_merge (
  input  logic                clk,
  input  logic                load,
  input  stmvp_pkg::acc_vec_t sums,
  output stmvp_pkg::q16_vec_t res
);
  import stmvp_pkg::*;

  q16_vec_t res_r;
  q16_vec_t res_nxt;

  // Floor shift by FRAC, then clamp to the 32-bit range.
  always_comb begin
    logic [51:0] sh;
    for (int r = 0; r < DIM; r++) begin
      sh = sums[r][67:FRAC];
      if (sh[51:31] == '0 || sh[51:31] == '1) begin
        res_nxt[r] = sh[31:0];
      end else begin
        res_nxt[r] = sums[r][67] ? Q16_MIN : Q16_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/stm_vector_propagate.sv =====
// 6x6 state transition matrix times perturbation vector, signed Q16.16.
// The matrix resets to the identity. An input transfer with operation = write
// stores entry_value at (entry_row, entry_col) in that cycle and returns
// nothing; a position above 5 is dropped. An input transfer with
// operation = vector returns one result, res0..res5, the product of the matrix
// (or, with use_inverse set, its symplectic inverse [D^T -B^T; -C^T A^T]) and
// the vector, floored to Q16.16 and saturated. The vector sees every write
// transferred before it. One item per cycle is taken back to back while in_stall is low;
// a result reaches the output register through the lane stages and the merge stage. Six
// row lanes run side by side, each a four-stage pipeline (coefficient capture,
// six 33x32 multiplies, pair sums, final sum), and a merge stage saturates and
// holds the result. Bubbles collapse, so input keeps flowing while a result
// waits on out_stall until every stage is full. Write use_inverse only while idle.
module stm_vector_propagate (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_use_inverse,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic        [2:0]  in_entry_row,
  input  logic        [2:0]  in_entry_col,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_vec0,
  input  logic signed [31:0] in_vec1,
  input  logic signed [31:0] in_vec2,
  input  logic signed [31:0] in_vec3,
  input  logic signed [31:0] in_vec4,
  input  logic signed [31:0] in_vec5,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res0,
  output logic signed [31:0] out_res1,
  output logic signed [31:0] out_res2,
  output logic signed [31:0] out_res3,
  output logic signed [31:0] out_res4,
  output logic signed [31:0] out_res5
);
  import stmvp_pkg::*;

  logic      use_inverse_r;
  logic      s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic      rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic      in_xfer, wr_xfer, vec_xfer;
  pipe_ctl_t ctl;
  coef_mat_t coef;
  q16_vec_t  vec;
  acc_vec_t  sums;
  q16_vec_t  res;

  // Stage ready chain: a stage loads when empty or when it drains downstream.
  assign rdy_out = !out_vld_r || !out_stall;
  assign rdy4    = !s4_vld_r  || rdy_out;
  assign rdy3    = !s3_vld_r  || rdy4;
  assign rdy2    = !s2_vld_r  || rdy3;
  assign rdy1    = !s1_vld_r  || rdy2;

  assign in_stall = !rdy1;
  assign in_xfer  = in_valid && !in_stall;
  assign wr_xfer  = in_xfer && (op_t'(in_operation) == OP_WRITE);
  assign vec_xfer = in_xfer && (op_t'(in_operation) == OP_VECTOR);

  assign ctl.s1_en = rdy1;
  assign ctl.s2_en = rdy2;
  assign ctl.s3_en = rdy3;
  assign ctl.s4_en = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_inverse_r <= 1'b0;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
      s3_vld_r      <= 1'b0;
      s4_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        use_inverse_r <= cfg_use_inverse;
      end
      if (rdy1)    s1_vld_r  <= vec_xfer;
      if (rdy2)    s2_vld_r  <= s1_vld_r;
      if (rdy3)    s3_vld_r  <= s2_vld_r;
      if (rdy4)    s4_vld_r  <= s3_vld_r;
      if (rdy_out) out_vld_r <= s4_vld_r;
    end
  end

  // Matrix store; coefficients are captured in the lanes at the vector transfer,
  // so a later write cannot disturb a vector already in flight.
  stmvp_mstore u_mstore (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (wr_xfer),
    .wr_row      (in_entry_row),
    .wr_col      (in_entry_col),
    .wr_data     (in_entry_value),
    .use_inverse (use_inverse_r),
    .coef        (coef)
  );

  assign vec[0] = in_vec0;
  assign vec[1] = in_vec1;
  assign vec[2] = in_vec2;
  assign vec[3] = in_vec3;
  assign vec[4] = in_vec4;
  assign vec[5] = in_vec5;

  // One lane per result row.
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    stmvp_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef[r]),
      .vec  (vec),
      .sum  (sums[r])
    );
  end

  stmvp_merge u_merge (
    .clk  (clk),
    .load (rdy_out),
    .sums (sums),
    .res  (res)
  );

  assign out_valid = out_vld_r;
  assign out_res0  = res[0];
  assign out_res1  = res[1];
  assign out_res2  = res[2];
  assign out_res3  = res[3];
  assign out_res4  = res[4];
  assign out_res5  = res[5];

  // Input only stalls when every stage holds a result and the output is blocked.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && out_vld_r && out_stall))
    else $error("input stalled with a bubble in the pipeline");

  // A new output result must come from the last lane stage.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s4_vld_r))
    else $error("output valid without a result in the last stage");

  // Only a vector transfer fills the first stage; writes never create results.
  a_s1_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s1_vld_r) |-> $past(vec_xfer))
    else $error("first stage filled without a vector transfer");

endmodule

// ===== tb/stm_vector_propagate_tb.sv =====
module stm_vector_propagate_tb;
  import stmvp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_use_inverse;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [2:0]  in_entry_row;
  logic [2:0]  in_entry_col;
  q16_t        in_entry_value;
  q16_t        in_vec0, in_vec1, in_vec2, in_vec3, in_vec4, in_vec5;
  logic        out_valid;
  logic        out_stall;
  q16_t        out_res0, out_res1, out_res2, out_res3, out_res4, out_res5;

  stm_vector_propagate u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_use_inverse (cfg_use_inverse),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_entry_row    (in_entry_row),
    .in_entry_col    (in_entry_col),
    .in_entry_value  (in_entry_value),
    .in_vec0         (in_vec0),
    .in_vec1         (in_vec1),
    .in_vec2         (in_vec2),
    .in_vec3         (in_vec3),
    .in_vec4         (in_vec4),
    .in_vec5         (in_vec5),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_res0        (out_res0),
    .out_res1        (out_res1),
    .out_res2        (out_res2),
    .out_res3        (out_res3),
    .out_res4        (out_res4),
    .out_res5        (out_res5)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the block: matrix entries and the inverse select.
  // ---------------------------------------------------------------------
  q16_t       stm_entries [DIM][DIM];
  logic       inverse_sel;

  // Products still owed by the block, oldest first.
  q16_vec_t   product_q [$];
  int         mismatch_count;

  // Idle controls: upper bound of the per-transfer wait on each side,
  // plus a long receiver hold counted down by the stall process.
  int         tx_max;
  int         rx_max;
  int         rx_wait;
  int         rx_hold_left;

  // Coefficient at (r, c), 33 bits so a negated most negative entry is +2^31.
  function automatic coef_t coef_at(int r, int c);
    coef_t x;
    if (!inverse_sel) begin
      x = coef_t'(stm_entries[r][c]);
    end else if (r < HALF && c < HALF) begin
      x = coef_t'(stm_entries[c + HALF][r + HALF]);
    end else if (r < HALF) begin
      x = coef_t'(stm_entries[c - HALF][r + HALF]);
      x = -x;
    end else if (c < HALF) begin
      x = coef_t'(stm_entries[c + HALF][r - HALF]);
      x = -x;
    end else begin
      x = coef_t'(stm_entries[c - HALF][r - HALF]);
    end
    return x;
  endfunction

  // Exact sum of six products, floored by 16 bits, then saturated.
  function automatic q16_vec_t predict_product(q16_vec_t v);
    q16_vec_t           res;
    logic signed [71:0] acc;
    logic signed [71:0] cx;
    logic signed [71:0] vx;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++) begin
        cx  = 72'(coef_at(r, c));
        vx  = 72'(v[c]);
        acc = acc + cx * vx;
      end
      acc = acc >>> FRAC;
      if (acc > Q16_MAX)      res[r] = Q16_MAX;
      else if (acc < Q16_MIN) res[r] = Q16_MIN;
      else                    res[r] = acc[31:0];
    end
    return res;
  endfunction

  // Value mix: extremes, full-range noise, and small magnitudes that keep
  // sums out of saturation.
  function automatic q16_t rand_q16();
    q16_t s;
    case ($urandom_range(0, 9))
      0: s = Q16_MAX;
      1: s = Q16_MIN;
      2: s = ZERO_Q16;
      3: s = ONE_Q16;
      4: s = -ONE_Q16;
      5, 6: s = $urandom;
      default: begin
        s = $urandom_range(0, 32'h7FFFF);
        s = s - 32'sh40000;
      end
    endcase
    return s;
  endfunction

  function automatic q16_vec_t rand_vec();
    q16_vec_t v;
    for (int k = 0; k < DIM; k++) v[k] = rand_q16();
    return v;
  endfunction

  function automatic q16_vec_t vec_all(q16_t x);
    q16_vec_t v;
    for (int k = 0; k < DIM; k++) v[k] = x;
    return v;
  endfunction

  task automatic report_mismatch(string what, q16_t got, q16_t want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: out_stall changes on the falling edge. A long hold wins over
  // the per-transfer wait drawn by the checker.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: a transfer on the rising edge is compared field by field
  // with the oldest owed product.
  always @(posedge clk) begin
    q16_vec_t got;
    q16_vec_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_res5, out_res4, out_res3, out_res2, out_res1, out_res0};
      if (product_q.size() == 0) begin
        report_mismatch("unexpected result res0", got[0], ZERO_Q16);
      end else begin
        want = product_q.pop_front();
        for (int k = 0; k < DIM; k++)
          if (got[k] !== want[k]) report_mismatch($sformatf("res%0d", k), got[k], want[k]);
      end
      rx_wait = $urandom_range(0, rx_max);
    end
  end

  // ---------------------------------------------------------------------
  // Sender: payload changes on the falling edge, transfer seen at the rising
  // edge. The shadow model advances at the transfer.
  // ---------------------------------------------------------------------
  task automatic send_item(op_t op, idx_t row, idx_t col, q16_t value, q16_vec_t vec);
    int gap;
    gap = $urandom_range(0, tx_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_row   <= row;
    in_entry_col   <= col;
    in_entry_value <= value;
    in_vec0        <= vec[0];
    in_vec1        <= vec[1];
    in_vec2        <= vec[2];
    in_vec3        <= vec[3];
    in_vec4        <= vec[4];
    in_vec5        <= vec[5];
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE) begin
      // out-of-range positions are dropped by the block
      if (row < DIM && col < DIM) stm_entries[row][col] = value;
    end else begin
      product_q.push_back(predict_product(vec));
    end
  endtask

  task automatic send_write(idx_t row, idx_t col, q16_t value);
    send_item(OP_WRITE, row, col, value, rand_vec());
  endtask

  task automatic send_vector(q16_vec_t vec);
    send_item(OP_VECTOR, idx_t'($urandom), idx_t'($urandom), q16_t'($urandom), vec);
  endtask

  // Stop offering, wait until every owed product has arrived, then let the
  // pipeline idle before returning.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_inverse(logic v);
    wait_drain();
    @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_use_inverse <= v;
    @(negedge clk);
    cfg_we          <= 1'b0;
    inverse_sel = v;
    @(posedge clk);
  endtask

  task automatic pick_idle_mode();
    int sel;
    sel = $urandom_range(0, 3);
    tx_max = (sel == 0) ? 0 : (sel == 1) ? 2 : 19;
    sel = $urandom_range(0, 3);
    rx_max = (sel == 0) ? 0 : (sel == 1) ? 2 : 19;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Identity after reset: products equal the vector, extremes included.
  task automatic test_identity();
    q16_vec_t v;
    send_vector(vec_all(Q16_MAX));
    send_vector(vec_all(Q16_MIN));
    send_vector(vec_all(ZERO_Q16));
    v = {Q16_MIN, Q16_MAX, -32'sd1, 32'sd1, -ONE_Q16, ONE_Q16};
    send_vector(v);
    // inverse of the identity is the identity
    set_inverse(1'b1);
    send_vector(v);
    set_inverse(1'b0);
  endtask

  // Extreme entries, dropped positions, saturation both ways, and the
  // negated most negative entry through the inverse.
  task automatic test_entry_extremes();
    q16_vec_t mixed;
    q16_vec_t unit0;
    send_write(3'd0, 3'd0, Q16_MAX);
    send_write(3'd0, 3'd1, Q16_MIN);
    send_write(3'd5, 3'd5, Q16_MIN);
    send_write(3'd2, 3'd4, Q16_MAX);
    send_write(3'd1, 3'd0, Q16_MAX);
    send_write(3'd1, 3'd1, Q16_MAX);
    send_write(3'd3, 3'd0, Q16_MIN);
    send_write(3'd6, 3'd0, Q16_MAX);
    send_write(3'd0, 3'd7, Q16_MAX);
    send_write(3'd7, 3'd6, Q16_MIN);
    mixed = {Q16_MIN, Q16_MAX, -ONE_Q16, ONE_Q16, Q16_MIN, Q16_MAX};
    unit0 = vec_all(ZERO_Q16);
    unit0[0] = ONE_Q16;
    send_vector(vec_all(Q16_MAX));
    send_vector(vec_all(Q16_MIN));
    send_vector(mixed);
    set_inverse(1'b1);
    send_vector(vec_all(Q16_MAX));
    send_vector(vec_all(Q16_MIN));
    send_vector(unit0);
    send_vector(mixed);
    set_inverse(1'b0);
  endtask

  // Receiver holds off for a long stretch while vectors keep coming back to
  // back, so the pipeline fills and in_stall rises.
  task automatic test_backpressure();
    tx_max = 0;
    rx_max = 0;
    rx_hold_left = 120;
    for (int i = 0; i < 40; i++) send_vector(rand_vec());
    wait_drain();
  endtask

  // Mixed writes and vectors; the idle mode changes every few dozen
  // transfers and the sender now and then waits for a full drain.
  task automatic test_random_traffic(int n_items);
    idx_t row;
    idx_t col;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) pick_idle_mode();
      if (i % 170 == 169) wait_drain();
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          row = idx_t'($urandom);
          col = idx_t'($urandom);
        end else begin
          row = idx_t'($urandom_range(0, DIM - 1));
          col = idx_t'($urandom_range(0, DIM - 1));
        end
        send_write(row, col, rand_q16());
      end else begin
        send_vector(rand_vec());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_use_inverse = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_WRITE;
    in_entry_row    = '0;
    in_entry_col    = '0;
    in_entry_value  = '0;
    in_vec0 = '0; in_vec1 = '0; in_vec2 = '0;
    in_vec3 = '0; in_vec4 = '0; in_vec5 = '0;
    out_stall       = 1'b0;
    mismatch_count  = 0;
    tx_max          = 0;
    rx_max          = 0;
    rx_wait         = 0;
    rx_hold_left    = 0;
    inverse_sel     = 1'b0;
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++)
        stm_entries[r][c] = (r == c) ? ONE_Q16 : ZERO_Q16;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity();
    test_entry_extremes();
    test_backpressure();
    set_inverse(1'b0);
    test_random_traffic(480);
    set_inverse(1'b1);
    test_random_traffic(480);
    set_inverse(1'b0);
    test_random_traffic(450);
    set_inverse(1'b1);
    test_random_traffic(450);

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && product_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== stm_vector_propagate.f =====
rtl/core/stmvp_pkg.sv
rtl/core/stmvp_mstore.sv
rtl/core/stmvp_lane.sv
rtl/core/stmvp_merge.sv
rtl/core/stm_vector_propagate.sv
tb/stm_vector_propagate_tb.sv
